>>> design/rbst_pkg.sv
package rbst_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int NUM_AXES        = 3;
  localparam int LIMIT_W         = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1;

  // per-lane control that travels beside the slab distances
  typedef struct packed {
    logic valid;
    logic par;      // direction counts as parallel to the slab
    logic in_slab;  // origin lies within [lo, hi] on this axis
  } lane_flags_t;

endpackage

>>> design/ray_box_slab_test_core.sv
// Ray versus axis-aligned box slab test. One item (origin, direction, box
// corners, all signed fixed point, Q16.16 by default) is taken every clock
// while start is high; busy is always low. Each result is marked by
// out_valid for one cycle and comes out in input order. The receiver
// cannot stall: results must be consumed as they appear. The slab
// dividers resolve one quotient bit per pipeline stage; throughput is one
// item per clock.
module ray_box_slab_test_core import rbst_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // item channel
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_lo_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_lo_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_lo_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_hi_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_hi_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_hi_z,
  // parallel_limit register
  input  logic                          cfg_we,
  input  logic [LIMIT_W-1:0]            cfg_wdata,
  // result channel
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed [COORD_WIDTH-1:0] out_t_entry
);

  // fully pipelined, never refuses an item
  assign busy = 1'b0;

  logic [LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  logic signed [COORD_WIDTH-1:0] o_a  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] d_a  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] lo_a [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] hi_a [NUM_AXES];

  assign o_a[0]  = in_origin_x;
  assign o_a[1]  = in_origin_y;
  assign o_a[2]  = in_origin_z;
  assign d_a[0]  = in_dir_x;
  assign d_a[1]  = in_dir_y;
  assign d_a[2]  = in_dir_z;
  assign lo_a[0] = in_box_lo_x;
  assign lo_a[1] = in_box_lo_y;
  assign lo_a[2] = in_box_lo_z;
  assign hi_a[0] = in_box_hi_x;
  assign hi_a[1] = in_box_hi_y;
  assign hi_a[2] = in_box_hi_z;

  lane_flags_t                   flags  [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] t_near [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] t_far  [NUM_AXES];

  // one lane per axis: slab distances, ordered
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbst_lane #(.CW(COORD_WIDTH), .FRAC(FRAC_BITS)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (start && !busy),
      .o        (o_a[a]),
      .d        (d_a[a]),
      .lo       (lo_a[a]),
      .hi       (hi_a[a]),
      .limit    (limit_r),
      .flags    (flags[a]),
      .t_near   (t_near[a]),
      .t_far    (t_far[a])
    );
  end

  // interval intersection and hit decision
  rbst_merge #(.CW(COORD_WIDTH)) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .flags       (flags),
    .t_near      (t_near),
    .t_far       (t_far),
    .out_valid   (out_valid),
    .out_hit     (out_hit),
    .out_t_entry (out_t_entry)
  );

endmodule

>>> design/rbst_div.sv
// Pipelined restoring divider: one quotient bit per stage.
// q = sat((n << FRAC) / d), truncated toward zero, sign from neg.
module rbst_div import rbst_pkg::*; #(
  parameter int CW   = COORD_WIDTH_DEF,
  parameter int FRAC = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [CW:0]          n_mag,
  input  logic [CW-1:0]        d_mag,
  input  logic                 neg,
  output logic signed [CW-1:0] q
);

  localparam int NW = CW + 1;
  localparam int QW = NW + FRAC;

  logic [QW-1:0] num_r [0:QW];
  logic [QW-1:0] quo_r [0:QW];
  logic [CW-1:0] rem_r [0:QW];
  logic [CW-1:0] den_r [0:QW];
  logic          neg_r [0:QW];
  logic signed [CW-1:0] q_r;

  always_ff @(posedge clk) begin
    num_r[0] <= {n_mag, {FRAC{1'b0}}};
    quo_r[0] <= '0;
    rem_r[0] <= '0;
    den_r[0] <= d_mag;
    neg_r[0] <= neg;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [CW:0] trial;
    logic [CW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem_r[k], num_r[k][QW-1]};
      diff  = trial - {1'b0, den_r[k]};
      ge    = (trial >= {1'b0, den_r[k]});
    end

    always_ff @(posedge clk) begin
      num_r[k+1] <= {num_r[k][QW-2:0], 1'b0};
      quo_r[k+1] <= {quo_r[k][QW-2:0], ge};
      rem_r[k+1] <= ge ? diff[CW-1:0] : trial[CW-1:0];
      den_r[k+1] <= den_r[k];
      neg_r[k+1] <= neg_r[k];
    end
  end

  // quotient at or above 2^(CW-1) clamps to the range end
  logic big;
  logic signed [CW-1:0] q_nxt;

  always_comb begin
    big = (quo_r[QW][QW-1:CW-1] != '0);
    if (neg_r[QW]) begin
      q_nxt = big ? {1'b1, {(CW-1){1'b0}}} : -$signed(quo_r[QW][CW-1:0]);
    end else begin
      q_nxt = big ? {1'b0, {(CW-1){1'b1}}} : $signed(quo_r[QW][CW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

>>> design/rbst_lane.sv
// One axis: slab distances via two dividers, ordered at the end.
module rbst_lane import rbst_pkg::*; #(
  parameter int CW   = COORD_WIDTH_DEF,
  parameter int FRAC = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] o,
  input  logic signed [CW-1:0] d,
  input  logic signed [CW-1:0] lo,
  input  logic signed [CW-1:0] hi,
  input  logic [LIMIT_W-1:0]   limit,
  output lane_flags_t          flags,
  output logic signed [CW-1:0] t_near,
  output logic signed [CW-1:0] t_far
);

  localparam int QW   = CW + 1 + FRAC;
  localparam int DLAT = QW + 2;

  logic signed [CW:0] diff_lo, diff_hi;
  logic [CW:0]        mag_lo, mag_hi;
  logic [CW-1:0]      d_mag;
  lane_flags_t        fl_in;

  always_comb begin
    diff_lo = $signed({lo[CW-1], lo}) - $signed({o[CW-1], o});
    diff_hi = $signed({hi[CW-1], hi}) - $signed({o[CW-1], o});
    mag_lo  = diff_lo[CW] ? -diff_lo : diff_lo;
    mag_hi  = diff_hi[CW] ? -diff_hi : diff_hi;
    d_mag   = d[CW-1] ? -d : d;
    fl_in.valid   = in_valid;
    fl_in.par     = (d_mag == '0) ||
                    ({{LIMIT_W{1'b0}}, d_mag} < {{CW{1'b0}}, limit});
    fl_in.in_slab = !((o < lo) || (o > hi));
  end

  logic signed [CW-1:0] q_lo, q_hi;

  rbst_div #(.CW(CW), .FRAC(FRAC)) u_div_lo (
    .clk   (clk),
    .n_mag (mag_lo),
    .d_mag (d_mag),
    .neg   (diff_lo[CW] ^ d[CW-1]),
    .q     (q_lo)
  );

  rbst_div #(.CW(CW), .FRAC(FRAC)) u_div_hi (
    .clk   (clk),
    .n_mag (mag_hi),
    .d_mag (d_mag),
    .neg   (diff_hi[CW] ^ d[CW-1]),
    .q     (q_hi)
  );

  // flags ride along with the divider latency
  lane_flags_t fl_r [0:DLAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLAT; i++) fl_r[i] <= '0;
    end else begin
      fl_r[0] <= fl_in;
      for (int i = 1; i < DLAT; i++) fl_r[i] <= fl_r[i-1];
    end
  end

  lane_flags_t          flags_r;
  logic signed [CW-1:0] t_near_r, t_far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= fl_r[DLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (q_lo > q_hi) begin
      t_near_r <= q_hi;
      t_far_r  <= q_lo;
    end else begin
      t_near_r <= q_lo;
      t_far_r  <= q_hi;
    end
  end

  assign flags  = flags_r;
  assign t_near = t_near_r;
  assign t_far  = t_far_r;

endmodule

>>> design/rbst_merge.sv
// Combine the three slabs: max of entries, min of exits over non-parallel slabs, then decide.
module rbst_merge import rbst_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lane_flags_t          flags  [NUM_AXES],
  input  logic signed [CW-1:0] t_near [NUM_AXES],
  input  logic signed [CW-1:0] t_far  [NUM_AXES],
  output logic                 out_valid,
  output logic                 out_hit,
  output logic signed [CW-1:0] out_t_entry
);

  logic signed [CW-1:0] near_c, far_c;
  logic                 ok_c;

  always_comb begin
    near_c = {1'b1, {(CW-1){1'b0}}};
    far_c  = {1'b0, {(CW-1){1'b1}}};
    ok_c   = 1'b1;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (flags[i].par) begin
        if (!flags[i].in_slab) ok_c = 1'b0;
      end else begin
        if (t_near[i] > near_c) near_c = t_near[i];
        if (t_far[i] < far_c) far_c = t_far[i];
      end
    end
  end

  logic                 valid_a_r, ok_a_r;
  logic signed [CW-1:0] near_a_r, far_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= flags[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    ok_a_r   <= ok_c;
    near_a_r <= near_c;
    far_a_r  <= far_c;
  end

  logic                 hit_nxt;
  logic                 valid_r, hit_r;
  logic signed [CW-1:0] t_entry_r;

  assign hit_nxt = ok_a_r && (near_a_r <= far_a_r) && !far_a_r[CW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    hit_r     <= hit_nxt;
    t_entry_r <= hit_nxt ? near_a_r : '0;
  end

  assign out_valid   = valid_r;
  assign out_hit     = hit_r;
  assign out_t_entry = t_entry_r;

endmodule

>>> tb/tb_ray_box_slab_test_core.sv
module tb_ray_box_slab_test_core;
  import rbst_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  // extra wait used by drain() after the last expected result
  localparam int LATENCY = CW + FB + 5;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic signed [CW-1:0] Q_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] Q_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE   = 1 <<< FB;

  typedef struct {
    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    logic signed [CW-1:0] lo  [3];
    logic signed [CW-1:0] hi  [3];
  } ray_box_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] t_entry;
  } slab_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [CW-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [CW-1:0] in_box_lo_x = '0, in_box_lo_y = '0, in_box_lo_z = '0;
  logic signed [CW-1:0] in_box_hi_x = '0, in_box_hi_y = '0, in_box_hi_z = '0;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic out_valid, out_hit;
  logic signed [CW-1:0] out_t_entry;

  ray_box_slab_test_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_box_lo_x(in_box_lo_x), .in_box_lo_y(in_box_lo_y), .in_box_lo_z(in_box_lo_z),
    .in_box_hi_x(in_box_hi_x), .in_box_hi_y(in_box_hi_y), .in_box_hi_z(in_box_hi_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_hit(out_hit), .out_t_entry(out_t_entry)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor's copy of the register
  logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;
  slab_result_t hits_pending [$];
  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_hits = 0;
  int idle_pct = 0;
  int idle_cycles = 0;

  // exact fixed-point slab distance, truncated toward zero, saturated
  function automatic logic signed [CW-1:0] slab_dist(logic signed [CW:0] num,
                                                     logic signed [CW-1:0] den);
    logic signed [2*CW+FB+1:0] q;
    q = ($signed({{(CW+FB+1){num[CW]}}, num}) <<< FB) / den;
    if (q > Q_MAX) return Q_MAX;
    if (q < Q_MIN) return Q_MIN;
    return q[CW-1:0];
  endfunction

  function automatic slab_result_t predict_slabs(ray_box_t rb);
    slab_result_t r;
    logic signed [CW-1:0] t_near, t_far, t1, t2, s;
    logic [CW-1:0] dm;
    logic ok;
    t_near = Q_MIN;
    t_far = Q_MAX;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      dm = rb.dir[a][CW-1] ? -rb.dir[a] : rb.dir[a];
      if (dm == 0 || dm < limit_shadow) begin
        if (rb.org[a] < rb.lo[a] || rb.org[a] > rb.hi[a]) ok = 1'b0;
      end else begin
        t1 = slab_dist(rb.lo[a] - rb.org[a], rb.dir[a]);
        t2 = slab_dist(rb.hi[a] - rb.org[a], rb.dir[a]);
        if (t1 > t2) begin
          s = t1; t1 = t2; t2 = s;
        end
        if (t1 > t_near) t_near = t1;
        if (t2 < t_far) t_far = t2;
        if (t_near > t_far) ok = 1'b0;
      end
    end
    r.hit = ok && t_far >= 0;
    r.t_entry = r.hit ? t_near : '0;
    return r;
  endfunction

  // sends one item, with random idle cycles ahead of it; start stays high
  // afterward so items can follow back to back
  task automatic send_ray(ray_box_t rb);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {in_origin_x, in_origin_y, in_origin_z} <= {rb.org[0], rb.org[1], rb.org[2]};
    {in_dir_x, in_dir_y, in_dir_z} <= {rb.dir[0], rb.dir[1], rb.dir[2]};
    {in_box_lo_x, in_box_lo_y, in_box_lo_z} <= {rb.lo[0], rb.lo[1], rb.lo[2]};
    {in_box_hi_x, in_box_hi_y, in_box_hi_z} <= {rb.hi[0], rb.hi[1], rb.hi[2]};
    @(posedge clk);
    while (busy) @(posedge clk);
    hits_pending.push_back(predict_slabs(rb));
    n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_shadow = v;
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return {$urandom()};
      1: return $signed($urandom_range(40 * 65536)) - 20 * 65536;
      2: return $signed($urandom_range(600)) - 300;
      3: return $urandom_range(1) ? Q_MAX : Q_MIN;
      default: return $signed($urandom_range(8 * 65536)) - 4 * 65536;
    endcase
  endfunction

  // mostly rays toward a box around a nearby target, with noise mixed in
  function automatic ray_box_t rand_ray();
    ray_box_t rb;
    logic signed [CW-1:0] c, h;
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(9) < 2) begin
        rb.org[a] = rand_coord(); rb.dir[a] = rand_coord();
        rb.lo[a] = rand_coord(); rb.hi[a] = rand_coord();
      end else begin
        c = $signed($urandom_range(20 * 65536)) - 10 * 65536;
        h = $urandom_range(4 * 65536);
        rb.lo[a] = c - h;
        rb.hi[a] = c + h;
        rb.org[a] = $signed($urandom_range(40 * 65536)) - 20 * 65536;
        case ($urandom_range(4))
          0: rb.dir[a] = $signed($urandom_range(600)) - 300;
          1: rb.dir[a] = {$urandom()};
          default: rb.dir[a] = (c - rb.org[a]) >>> $urandom_range(6);
        endcase
      end
    end
    return rb;
  endfunction

  // results are checked in order; no stall is possible on this side
  always @(posedge clk) begin
    slab_result_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (hits_pending.size() == 0) begin
        $error("result with nothing expected: hit=%0d t_entry=%0d", out_hit, out_t_entry);
        n_errors++;
      end else begin
        want = hits_pending.pop_front();
        if (want.hit) n_hits++;
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_hit);
          n_errors++;
        end
        if (out_t_entry !== want.t_entry) begin
          $error("t_entry: expected %0d, got %0d", want.t_entry, out_t_entry);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item or result while work is pending
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || hits_pending.size() == 0 && !start)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic ray_box_t axis_ray(logic signed [CW-1:0] o, logic signed [CW-1:0] d,
                                        logic signed [CW-1:0] l, logic signed [CW-1:0] h);
    ray_box_t rb;
    for (int a = 0; a < 3; a++) begin
      rb.org[a] = 0; rb.dir[a] = 0; rb.lo[a] = -ONE; rb.hi[a] = ONE;
    end
    rb.org[0] = o; rb.dir[0] = d; rb.lo[0] = l; rb.hi[0] = h;
    return rb;
  endfunction

  task automatic test_directed();
    ray_box_t rb;
    idle_pct = 0;
    send_ray(axis_ray(-4 * ONE, ONE, -ONE, ONE));          // plain hit ahead
    send_ray(axis_ray(4 * ONE, ONE, -ONE, ONE));           // box behind
    send_ray(axis_ray(0, ONE, -ONE, ONE));                 // origin in the box
    send_ray(axis_ray(-4 * ONE, -ONE, -ONE, ONE));         // pointing away
    send_ray(axis_ray(0, 0, -ONE, ONE));                   // zero dir, in slab
    send_ray(axis_ray(2 * ONE, 0, -ONE, ONE));             // zero dir, outside
    send_ray(axis_ray(0, 0, ONE, -ONE));                   // parallel, inverted box
    send_ray(axis_ray(-4 * ONE, ONE, ONE, -ONE));          // inverted box, moving
    send_ray(axis_ray(Q_MIN, 1, Q_MIN, Q_MAX));            // saturating distance
    send_ray(axis_ray(Q_MAX, Q_MIN, Q_MIN, Q_MAX));
    send_ray(axis_ray(Q_MIN, Q_MAX, Q_MAX, Q_MAX));
    send_ray(axis_ray(Q_MAX, -1, Q_MIN, Q_MIN));
    send_ray(axis_ray(0, 1, 0, 0));                        // tiny direction at limit
    send_ray(axis_ray(-ONE, 3, 5, 7));                     // truncation
    send_ray(axis_ray(ONE, -3, -7, -5));
    for (int a = 0; a < 3; a++) begin
      rb.org[a] = 32'hffffffff; rb.dir[a] = 32'hffffffff;
      rb.lo[a] = 32'hffffffff; rb.hi[a] = 32'hffffffff;
    end
    send_ray(rb);                                          // all ones
    drain();
  endtask

  task automatic test_limits();
    write_limit(16'd0);
    send_ray(axis_ray(0, 0, -ONE, ONE));                   // zero stays parallel
    send_ray(axis_ray(2 * ONE, 0, -ONE, ONE));
    send_ray(axis_ray(-ONE, 1, 0, 2));
    write_limit(16'hffff);
    send_ray(axis_ray(-ONE, 16'hfffe, 0, 2));              // below limit
    send_ray(axis_ray(-ONE, 16'hffff, 0, 2));              // at limit
    send_ray(axis_ray(-ONE, -32'sd65535, 0, 2));
    drain();
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) send_ray(rand_ray());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limits();
    write_limit(16'd1);
    test_random(250, 0);
    write_limit(16'd300);
    test_random(250, 84);
    // hold off until the pipeline is empty, then resume
    drain();
    write_limit($urandom());
    test_random(250, 35);
    write_limit(16'd0);
    test_random(150, 0);
    write_limit(16'hffff);
    test_random(150, 84);
    drain();
    $display("%0d items, %0d results (%0d hits): directed cases, several limit settings",
             n_items, n_results, n_hits);
    $display("and random rays with the sender idle 0, 35 and 84 percent of cycles");
    if (n_errors == 0 && hits_pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
